### rtl/core/strike_count_ban_table_macros.svh
// assertion macros for the strike count ban table
// used by strike_count_ban_table.sv under rtl/core; no other dependencies
`ifndef STRIKE_COUNT_BAN_TABLE_MACROS_SVH
`define STRIKE_COUNT_BAN_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// clocked check with active-low reset masking
`define SCBT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("strike_count_ban_table: assertion failed");

// clocked check that also holds during reset
`define SCBT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("strike_count_ban_table: assertion failed");

`else

`define SCBT_ASSERT(lbl, clk, rst_n, prop)
`define SCBT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/scbt_pkg.sv
// shared types and constants of the strike count ban table
// no dependencies; imported by strike_count_ban_table and the testbench
`timescale 1ns / 1ps

package scbt_pkg;

    // table size default
    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    // register reset values
    localparam logic [7:0]  LIMIT_RESET  = 8'd3;
    localparam logic [31:0] WINDOW_RESET = 32'd600;
    localparam logic [31:0] BAN_RESET    = 32'd3600;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIKE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAG_WINDOW   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAN_LENGTH   = 2'd2;

    // item kinds
    localparam logic FUNC_STRIKE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // result actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_LOCAL    = 3'd1;
    localparam logic [2:0] ACT_WINDOW   = 3'd2;
    localparam logic [2:0] ACT_COUNTED  = 3'd3;
    localparam logic [2:0] ACT_BANNED   = 3'd4;
    localparam logic [2:0] ACT_EXTENDED = 3'd5;
    localparam logic [2:0] ACT_UNBANNED = 3'd6;
    localparam logic [2:0] ACT_FULL     = 3'd7;

    // local networks that never collect strikes
    localparam logic [31:0] LOOPBACK_MASK = 32'hFF00_0000;
    localparam logic [31:0] LOOPBACK_NET  = 32'h7F00_0000;
    localparam logic [31:0] HOMENET_MASK  = 32'hFFFF_FF00;
    localparam logic [31:0] HOMENET_NET   = 32'hC0A8_B200;

    // one table entry as stored in memory
    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [7:0]  count;
        logic [31:0] expiry;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/core/scbt_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module scbt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/strike_count_ban_table.sv
// Strike counting ban table for IPv4 addresses, table held in one ram.
// Depends on scbt_pkg, scbt_ram and strike_count_ban_table_macros.svh.
`timescale 1ns / 1ps
`include "strike_count_ban_table_macros.svh"

// Each input beat is either a strike (func 0) or a time tick (func 1) and yields exactly one
// result beat. A strike from 127.0.0.0/8 or 192.168.178.0/24, or one that lags now_time by
// more than the lag window register, goes from ST_CHECK straight to ST_DONE with no scan. Any
// other item walks the whole table through the single read port of the entry ram, one entry
// per cycle, then through ST_RESOLVE and ST_DONE; the next beat can be taken as soon as its
// result moves to the output register. The result register lets a new item start while the
// previous result waits; that item stalls once its own result is ready until the output
// is taken. After reset the ram is cleared one entry per cycle, so inputs are held off until
// every entry is cleared; configuration writes are taken at any time and must only be
// issued while the block is idle.
module strike_count_ban_table
    import scbt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    // input items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [31:0]            s_ip_address,
    input  logic [31:0]            s_event_time,
    input  logic [7:0]             s_weight,
    input  logic [31:0]            s_now_time,
    // results
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_action,
    output logic [31:0]            m_ip_out
);

    localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RESOLVE,
        ST_DONE
    } state_t;

    // control registers
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_action_reg, m_action_next;
    logic [31:0]      m_ip_reg, m_ip_next;

    // configuration registers
    logic [7:0]  strike_limit_reg;
    logic [31:0] lag_window_reg;
    logic [31:0] ban_length_reg;

    // item and scan datapath registers
    logic              func_reg, func_next;
    logic [31:0]       ip_reg, ip_next;
    logic [31:0]       time_reg, time_next;
    logic [7:0]        weight_reg, weight_next;
    logic [31:0]       now_reg, now_next;
    logic [31:0]       expiry_reg, expiry_next;
    logic [ADDR_W-1:0] chk_slot_reg, chk_slot_next;
    logic              match_found_reg, match_found_next;
    logic [ADDR_W-1:0] match_slot_reg, match_slot_next;
    logic [7:0]        match_count_reg, match_count_next;
    logic              free_found_reg, free_found_next;
    logic [ADDR_W-1:0] free_slot_reg, free_slot_next;
    logic              best_found_reg, best_found_next;
    logic [ADDR_W-1:0] best_slot_reg, best_slot_next;
    logic [31:0]       best_ip_reg, best_ip_next;
    logic [31:0]       best_exp_reg, best_exp_next;
    logic [2:0]        res_action_reg, res_action_next;
    logic [31:0]       res_ip_reg, res_ip_next;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wentry;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_entry;

    // combinational helpers
    logic [7:0]  eff_limit;
    logic        is_local;
    logic [32:0] window_sum;
    logic [32:0] expiry_sum;
    logic        scan_issue;
    logic [7:0]  add_amt;
    logic [7:0]  before_cnt;
    logic [8:0]  after_sum;
    logic [7:0]  after_cnt;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_action  = m_action_reg;
    assign m_ip_out  = m_ip_reg;

    assign eff_limit = (strike_limit_reg == 8'd0) ? 8'd1 : strike_limit_reg;
    assign rd_entry  = entry_t'(ram_rdata);
    assign out_free  = !m_valid_reg || m_ready;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strike_limit_reg <= LIMIT_RESET;
            lag_window_reg   <= WINDOW_RESET;
            ban_length_reg   <= BAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STRIKE_LIMIT: strike_limit_reg <= cfg_data[7:0];
                CFG_LAG_WINDOW:   lag_window_reg   <= cfg_data;
                CFG_BAN_LENGTH:   ban_length_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // strike pre-checks on the captured item
    assign is_local = ((ip_reg & LOOPBACK_MASK) == LOOPBACK_NET) ||
                      ((ip_reg & HOMENET_MASK) == HOMENET_NET);
    assign window_sum = {1'b0, time_reg} + {1'b0, lag_window_reg};
    assign expiry_sum = {1'b0, time_reg} + {1'b0, ban_length_reg};

    // count update for the chosen slot
    assign add_amt    = (weight_reg == 8'd0) ? 8'd1 :
                        ((weight_reg < eff_limit) ? weight_reg : eff_limit);
    assign before_cnt = match_found_reg ? match_count_reg : 8'd0;
    assign after_sum  = {1'b0, before_cnt} + {1'b0, add_amt};
    assign after_cnt  = (after_sum > {1'b0, eff_limit}) ? eff_limit : after_sum[7:0];

    assign scan_issue = (scan_cnt_reg != SCAN_END);
    assign ram_raddr  = scan_cnt_reg[ADDR_W-1:0];

    // sequencer next state
    always_comb begin
        state_next       = state_reg;
        scan_cnt_next    = scan_cnt_reg;
        chk_vld_next     = 1'b0;
        m_valid_next     = m_valid_reg;
        m_action_next    = m_action_reg;
        m_ip_next        = m_ip_reg;

        func_next        = func_reg;
        ip_next          = ip_reg;
        time_next        = time_reg;
        weight_next      = weight_reg;
        now_next         = now_reg;
        expiry_next      = expiry_reg;
        chk_slot_next    = chk_slot_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        match_count_next = match_count_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        best_found_next  = best_found_reg;
        best_slot_next   = best_slot_reg;
        best_ip_next     = best_ip_reg;
        best_exp_next    = best_exp_reg;
        res_action_next  = res_action_reg;
        res_ip_next      = res_ip_reg;

        ram_we     = 1'b0;
        ram_waddr  = scan_cnt_reg[ADDR_W-1:0];
        ram_wentry = '0;

        // result beat taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // wipe every entry after reset
            ST_CLEAR: begin
                if (scan_issue) begin
                    ram_we        = 1'b1;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end else begin
                    state_next = ST_IDLE;
                end
            end

            // capture the item and reset the scan trackers
            ST_IDLE: begin
                if (s_valid) begin
                    func_next        = s_func;
                    ip_next          = s_ip_address;
                    time_next        = s_event_time;
                    weight_next      = s_weight;
                    now_next         = s_now_time;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    best_found_next  = 1'b0;
                    scan_cnt_next    = '0;
                    state_next       = ST_CHECK;
                end
            end

            // local and window rejects, expiry with saturation
            ST_CHECK: begin
                expiry_next = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];
                res_ip_next = ip_reg;
                if (func_reg == FUNC_TICK) begin
                    state_next = ST_SCAN;
                end else if (is_local) begin
                    res_action_next = ACT_LOCAL;
                    state_next      = ST_DONE;
                end else if (window_sum < {1'b0, now_reg}) begin
                    res_action_next = ACT_WINDOW;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end

            // one read per cycle, data examined once the registered read returns
            ST_SCAN: begin
                if (scan_issue) begin
                    chk_vld_next  = 1'b1;
                    chk_slot_next = scan_cnt_reg[ADDR_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (chk_vld_reg) begin
                    if (func_reg == FUNC_TICK) begin
                        if (rd_entry.valid && (rd_entry.count >= eff_limit) &&
                            (!best_found_reg || (rd_entry.expiry < best_exp_reg))) begin
                            best_found_next = 1'b1;
                            best_slot_next  = chk_slot_reg;
                            best_ip_next    = rd_entry.ip;
                            best_exp_next   = rd_entry.expiry;
                        end
                    end else begin
                        if (rd_entry.valid && (rd_entry.ip == ip_reg) && !match_found_reg) begin
                            match_found_next = 1'b1;
                            match_slot_next  = chk_slot_reg;
                            match_count_next = rd_entry.count;
                        end
                        if (!rd_entry.valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_slot_next  = chk_slot_reg;
                        end
                    end
                end
                if (!scan_issue && !chk_vld_reg) begin
                    state_next = ST_RESOLVE;
                end
            end

            // at most one write back of the chosen entry
            ST_RESOLVE: begin
                state_next = ST_DONE;
                if (func_reg == FUNC_TICK) begin
                    if (best_found_reg && (best_exp_reg <= now_reg)) begin
                        ram_we            = 1'b1;
                        ram_waddr         = best_slot_reg;
                        ram_wentry.valid  = 1'b0;
                        ram_wentry.ip     = best_ip_reg;
                        ram_wentry.count  = 8'd0;
                        ram_wentry.expiry = best_exp_reg;
                        res_action_next   = ACT_UNBANNED;
                        res_ip_next       = best_ip_reg;
                    end else begin
                        res_action_next = ACT_NONE;
                        res_ip_next     = 32'd0;
                    end
                end else if (!match_found_reg && !free_found_reg) begin
                    res_action_next = ACT_FULL;
                end else begin
                    ram_we            = 1'b1;
                    ram_waddr         = match_found_reg ? match_slot_reg : free_slot_reg;
                    ram_wentry.valid  = 1'b1;
                    ram_wentry.ip     = ip_reg;
                    ram_wentry.count  = after_cnt;
                    ram_wentry.expiry = expiry_reg;
                    if (before_cnt >= eff_limit) begin
                        res_action_next = ACT_EXTENDED;
                    end else if (after_cnt >= eff_limit) begin
                        res_action_next = ACT_BANNED;
                    end else begin
                        res_action_next = ACT_COUNTED;
                    end
                end
            end

            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = res_action_reg;
                    m_ip_next     = res_ip_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            scan_cnt_reg <= '0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_action_reg <= ACT_NONE;
            m_ip_reg     <= 32'd0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            chk_vld_reg  <= chk_vld_next;
            m_valid_reg  <= m_valid_next;
            m_action_reg <= m_action_next;
            m_ip_reg     <= m_ip_next;
        end
    end

    // item and scan datapath
    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        ip_reg          <= ip_next;
        time_reg        <= time_next;
        weight_reg      <= weight_next;
        now_reg         <= now_next;
        expiry_reg      <= expiry_next;
        chk_slot_reg    <= chk_slot_next;
        match_found_reg <= match_found_next;
        match_slot_reg  <= match_slot_next;
        match_count_reg <= match_count_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        best_found_reg  <= best_found_next;
        best_slot_reg   <= best_slot_next;
        best_ip_reg     <= best_ip_next;
        best_exp_reg    <= best_exp_next;
        res_action_reg  <= res_action_next;
        res_ip_reg      <= res_ip_next;
    end

    // entry table
    scbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(ADDR_W)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // checks on the sequencer
    `SCBT_ASSERT(a_no_write_in_scan, aclk, aresetn, (state_reg == ST_SCAN) |-> !ram_we)
    `SCBT_ASSERT(a_accept_to_check, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_CHECK))
    `SCBT_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
    `SCBT_ASSERT(a_read_beat_in_scan, aclk, aresetn, chk_vld_reg |-> $past(state_reg == ST_SCAN))
    `SCBT_ASSERT_ALWAYS(a_no_accept_in_reset, aclk, !aresetn |=> !s_ready)

endmodule

### tb/strike_count_ban_table_tb.sv
// self-checking testbench for the strike count ban table
// depends on scbt_pkg and strike_count_ban_table; drives items, checks every result beat
`timescale 1ns / 1ps

module strike_count_ban_table_tb;
    import scbt_pkg::*;

    localparam int DEPTH     = TABLE_ENTRIES_DEF;
    localparam int HOLD_LONG = 300;

    typedef struct packed {
        logic        func;
        logic [31:0] ip;
        logic [31:0] evt;
        logic [7:0]  weight;
        logic [31:0] now;
    } ban_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] ip;
    } verdict_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_func       = 1'b0;
    logic [31:0]            s_ip_address = '0;
    logic [31:0]            s_event_time = '0;
    logic [7:0]             s_weight     = '0;
    logic [31:0]            s_now_time   = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [2:0]             m_action;
    logic [31:0]            m_ip_out;

    // predictor copy of registers and table
    logic [7:0]  lim_reg    = LIMIT_RESET;
    logic [31:0] window_reg = WINDOW_RESET;
    logic [31:0] ban_reg    = BAN_RESET;
    logic        tbl_valid  [DEPTH];
    logic [31:0] tbl_ip     [DEPTH];
    logic [7:0]  tbl_count  [DEPTH];
    logic [31:0] tbl_expiry [DEPTH];

    ban_item_t item_feed[$];
    verdict_t  owed_verdicts[$];
    ban_item_t cur_item;
    int        fails = 0;

    // traffic shaping knobs set by the sequence
    logic        src_gaps_on    = 1'b0;
    logic        sink_stalls_on = 1'b0;
    logic        hold_arm       = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;
    int          src_gap        = 0;
    int          sink_gap       = 0;
    logic [31:0] clock_s        = 32'd1000;
    logic [31:0] ip_pool [128];

    strike_count_ban_table dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_ip_address (s_ip_address),
        .s_event_time (s_event_time),
        .s_weight     (s_weight),
        .s_now_time   (s_now_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_ip_out     (m_ip_out)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // expected action of one item, updating the predicted table
    function automatic verdict_t ban_verdict(input ban_item_t it);
        verdict_t    v;
        int unsigned lim, add, prior, total;
        logic [32:0] reach, exp33;
        int          hit, hole, best;
        lim  = (lim_reg == 8'd0) ? 1 : lim_reg;
        hit  = -1;
        hole = -1;
        best = -1;
        v.action = ACT_NONE;
        v.ip     = it.ip;
        if (it.func == FUNC_TICK) begin
            v.ip = '0;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && tbl_count[i] >= lim &&
                    (best < 0 || tbl_expiry[i] < tbl_expiry[best])) begin
                    best = i;
                end
            end
            if (best >= 0 && tbl_expiry[best] <= it.now) begin
                tbl_valid[best] = 1'b0;
                v.action = ACT_UNBANNED;
                v.ip     = tbl_ip[best];
            end
            return v;
        end
        if (((it.ip & LOOPBACK_MASK) == LOOPBACK_NET) ||
            ((it.ip & HOMENET_MASK) == HOMENET_NET)) begin
            v.action = ACT_LOCAL;
            return v;
        end
        // window test without wrap
        reach = {1'b0, it.evt} + {1'b0, window_reg};
        if (reach < {1'b0, it.now}) begin
            v.action = ACT_WINDOW;
            return v;
        end
        // expiry saturates at the top of the range
        exp33 = {1'b0, it.evt} + {1'b0, ban_reg};
        if (exp33[32]) exp33 = {1'b0, 32'hFFFF_FFFF};
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i]) begin
                if (hit < 0 && tbl_ip[i] == it.ip) hit = i;
            end else if (hole < 0) begin
                hole = i;
            end
        end
        if (hit < 0) begin
            if (hole < 0) begin
                v.action = ACT_FULL;
                return v;
            end
            hit = hole;
            tbl_valid[hit] = 1'b1;
            tbl_ip[hit]    = it.ip;
            tbl_count[hit] = 8'd0;
        end
        add = (it.weight < lim) ? it.weight : lim;
        if (add == 0) add = 1;
        prior = tbl_count[hit];
        total = prior + add;
        if (total > lim) total = lim;
        tbl_count[hit]  = 8'(total);
        tbl_expiry[hit] = exp33[31:0];
        if (prior >= lim) v.action = ACT_EXTENDED;
        else if (total >= lim) v.action = ACT_BANNED;
        else v.action = ACT_COUNTED;
        return v;
    endfunction

    // input driver: one beat at a time from the feed, with random gaps when enabled
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                owed_verdicts = {owed_verdicts, ban_verdict(cur_item)};
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (src_gaps_on && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else if (item_feed.size() != 0) begin
                    cur_item = item_feed.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= cur_item.func;
                    s_ip_address <= cur_item.ip;
                    s_event_time <= cur_item.evt;
                    s_weight     <= cur_item.weight;
                    s_now_time   <= cur_item.now;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each beat with the oldest owed verdict
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_verdicts.size() == 0) begin
                    $error("unexpected result: action %0d ip %h", m_action, m_ip_out);
                    fails++;
                end else begin
                    want = owed_verdicts.pop_front();
                    if (m_action !== want.action) begin
                        $error("action: expected %0d, actual %0d", want.action, m_action);
                        fails++;
                    end
                    if (m_ip_out !== want.ip) begin
                        $error("ip_out: expected %h, actual %h", want.ip, m_ip_out);
                        fails++;
                    end
                end
            end
            // long hold-off counted here, then short random stalls
            if (hold_arm != hold_seen) begin
                hold_seen <= hold_arm;
                hold_left <= HOLD_LONG;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(0, 4);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_strike(input logic [31:0] ip, input logic [31:0] evt,
                               input logic [7:0] weight, input logic [31:0] now);
        ban_item_t it;
        it.func   = FUNC_STRIKE;
        it.ip     = ip;
        it.evt    = evt;
        it.weight = weight;
        it.now    = now;
        item_feed = {item_feed, it};
    endtask

    task automatic push_tick(input logic [31:0] now);
        ban_item_t it;
        it.func   = FUNC_TICK;
        it.ip     = $urandom;
        it.evt    = $urandom;
        it.weight = 8'($urandom);
        it.now    = now;
        item_feed = {item_feed, it};
    endtask

    // register write beat; predictor follows at the accepting edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STRIKE_LIMIT: lim_reg    = val[7:0];
            CFG_LAG_WINDOW:   window_reg = val;
            CFG_BAN_LENGTH:   ban_reg    = val;
            default: ;
        endcase
    endtask

    // wait until the feed is sent and every result is back
    task automatic settle();
        do @(negedge aclk);
        while (item_feed.size() != 0 || s_valid || owed_verdicts.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_items(input int count, input int pool_n);
        int          r;
        logic [31:0] ip, evt, now;
        logic [7:0]  weight;
        for (int n = 0; n < count; n++) begin
            clock_s = clock_s + $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 9);
                if (r < 4) push_tick(clock_s);
                else if (r < 8) push_tick(clock_s + ban_reg);
                else push_tick($urandom);
            end else begin
                // address: mostly a small repeating pool, some local, some fresh
                r = $urandom_range(0, 99);
                if (r < 5) ip = LOOPBACK_NET | ($urandom & ~LOOPBACK_MASK);
                else if (r < 10) ip = HOMENET_NET | ($urandom & ~HOMENET_MASK);
                else if (r < 80) ip = ip_pool[$urandom_range(0, pool_n - 1)];
                else ip = $urandom;
                r = $urandom_range(0, 99);
                if (r < 60) evt = clock_s - $urandom_range(0, 200);
                else if (r < 75) evt = clock_s - $urandom_range(0, 5000);
                else if (r < 85) evt = clock_s + $urandom_range(0, 100);
                else evt = $urandom;
                now = ($urandom_range(0, 6) == 0) ? $urandom : clock_s;
                r = $urandom_range(0, 9);
                if (r < 5) weight = 8'($urandom_range(0, 3));
                else if (r < 8) weight = 8'($urandom_range(0, 10));
                else weight = 8'($urandom_range(0, 255));
                push_strike(ip, evt, weight, now);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] lim, input logic [31:0] win,
                             input logic [31:0] ban, input int pool_n, input int count,
                             input logic gaps);
        write_reg(CFG_STRIKE_LIMIT, {24'd0, lim});
        write_reg(CFG_LAG_WINDOW, win);
        write_reg(CFG_BAN_LENGTH, ban);
        src_gaps_on    = gaps;
        sink_stalls_on = gaps;
        random_items(count, pool_n);
        settle();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_ip[i]     = '0;
            tbl_count[i]  = '0;
            tbl_expiry[i] = '0;
        end
        for (int i = 0; i < 128; i++) ip_pool[i] = $urandom;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty tick, local nets, window edges, weights, bans, ties
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        push_tick(32'd0);
        push_strike(32'h7F00_0000, 32'd0, 8'd0, 32'd0);
        push_strike(32'h7FFF_FFFF, 32'd0, 8'd1, 32'd0);
        push_strike(32'hC0A8_B200, 32'd0, 8'd1, 32'd0);
        push_strike(32'hC0A8_B2FF, 32'd0, 8'd1, 32'd0);
        push_strike(32'hC0A8_B301, 32'd1000, 8'd1, 32'd1000);
        push_strike(32'h7EFF_FFFF, 32'd1000, 8'd0, 32'd1600);
        push_strike(32'h0A00_0001, 32'd1000, 8'd1, 32'd1601);
        push_strike(32'h0000_0000, 32'd2000, 8'd255, 32'd2000);
        push_strike(32'h0000_0000, 32'd1500, 8'd1, 32'd2000);
        push_strike(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2, 32'hFFFF_FFFF);
        push_strike(32'hFFFF_FFFF, 32'hFFFF_FFF0, 8'd1, 32'd0);
        push_strike(32'hC0A8_B301, 32'd3000, 8'd7, 32'd3000);
        push_tick(32'd5099);
        push_tick(32'd5100);
        push_tick(32'hFFFF_FFFE);
        push_tick(32'hFFFF_FFFE);
        push_tick(32'hFFFF_FFFF);
        push_tick(32'hFFFF_FFFF);
        push_strike(32'h8000_0000, 32'h8000_0000, 8'h80, 32'h7FFF_FFFF);
        push_strike(32'h0102_0304, 32'd100, 8'd3, 32'd100);
        push_strike(32'h0102_0305, 32'd100, 8'd3, 32'd100);
        push_tick(32'd3700);
        push_tick(32'd3700);
        settle();

        // long receiver hold-off while the sender keeps offering
        @(posedge aclk);
        hold_arm <= ~hold_arm;
        run_phase(8'd3, 32'd600, 32'd3600, 12, 200, 1'b1);
        // wide pool with a high limit fills the table
        run_phase(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 150, 1'b1);
        // limit one bans every entry; late ticks then empty the table
        write_reg(CFG_STRIKE_LIMIT, 32'd1);
        for (int i = 0; i < DEPTH + 2; i++) push_tick(32'hFFFF_FFFF);
        settle();
        run_phase(8'd1, 32'd0, 32'd0, 10, 150, 1'b0);
        run_phase(8'd0, 32'd100, 32'd50, 20, 150, 1'b1);
        run_phase(8'd5, 32'd1000, 32'd500, 16, 150, 1'b1);
        // lowered limit, no idling to the end
        run_phase(8'd2, 32'd600, 32'd3600, 16, 150, 1'b0);

        repeat (100) @(posedge aclk);
        if (fails == 0 && owed_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/scbt_pkg.sv
rtl/core/scbt_ram.sv
rtl/core/strike_count_ban_table.sv
tb/strike_count_ban_table_tb.sv
